@@ src/srfs_pkg.sv @@
// shared widths, codes, control structs and the month term table
// for the step record filtered statistics block; no dependencies
package srfs_pkg;

	localparam int DAY_W      = 5;
	localparam int MON_W      = 4;
	localparam int YEAR_W     = 14;
	localparam int STEP_W     = 24;
	localparam int TOTAL_W    = 17;
	localparam int MODE_W     = 2;
	localparam int WD_W       = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// weekday arithmetic widths
	localparam int YY_W  = 15;
	localparam int J_W   = 8;
	localparam int K_W   = 7;
	localparam int H_W   = 11;
	localparam int Q7_W  = 8;
	localparam int MT_W  = 6;

	localparam int YEAR_OFFSET = 400;
	localparam int MONTH_WRAP  = 3;
	localparam int CENT        = 100;
	localparam int WEEK        = 7;
	localparam int J_WEIGHT    = 5;
	localparam int RECIP100    = 5243;
	localparam int RECIP100_SH = 19;
	localparam int RECIP7      = 2341;
	localparam int RECIP7_SH   = 14;

	localparam logic [MODE_W-1:0] MODE_ALL     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MONTH   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WEEKDAY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MONTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WEEKDAY = 2'd2;

	localparam logic [MON_W-1:0] FMON_RESET = 4'd1;

	typedef struct packed {
		logic take;
		logic start;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic div_done;
	} dp_stat_t;

	// floor(26 * (m + 1) / 10), with months below march moved up by twelve
	function automatic logic [MT_W-1:0] month_term(input logic [MON_W-1:0] m);
		logic [MT_W-1:0] t;
		case (m)
			4'd0:    t = 6'd33;
			4'd1:    t = 6'd36;
			4'd2:    t = 6'd39;
			4'd3:    t = 6'd10;
			4'd4:    t = 6'd13;
			4'd5:    t = 6'd15;
			4'd6:    t = 6'd18;
			4'd7:    t = 6'd20;
			4'd8:    t = 6'd23;
			4'd9:    t = 6'd26;
			4'd10:   t = 6'd28;
			4'd11:   t = 6'd31;
			4'd12:   t = 6'd33;
			4'd13:   t = 6'd36;
			4'd14:   t = 6'd39;
			default: t = 6'd41;
		endcase
		return t;
	endfunction

endpackage

@@ src/srfs_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
// depends on nothing; used by srfs_datapath
module srfs_div #(
	parameter int DVD_W = 41,
	parameter int DVS_W = 17,
	parameter int Q_W   = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [Q_W-1:0]   quotient
);

	localparam int C_W = (Q_W > 1) ? $clog2(Q_W) : 1;

	logic [DVD_W-1:0] rem_q;
	logic [DVD_W-1:0] dvs_q;
	logic [Q_W-1:0]   quo_q;
	logic [C_W-1:0]   cnt_q;
	logic             run_q;
	logic             done_q;
	logic             ge;

	assign ge = rem_q >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= C_W'(Q_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= DVD_W'(divisor) << (Q_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_last_bit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && !start && cnt_q == '0) |=> (done_q && !run_q))
		else $error("divider did not finish after its last bit");

endmodule

@@ src/srfs_datapath.sv @@
// weekday pipeline, filter, accumulators, result snapshot and output registers
// depends on srfs_pkg and srfs_div
module srfs_datapath #(
	parameter int MAX_RECORDS = 65536,
	parameter int STEP_BITS   = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [srfs_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [srfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [srfs_pkg::DAY_W-1:0]        rec_day,
	input  logic [srfs_pkg::MON_W-1:0]        rec_month,
	input  logic [srfs_pkg::YEAR_W-1:0]       rec_year,
	input  logic [srfs_pkg::STEP_W-1:0]       step_count,
	input  srfs_pkg::dp_cmd_t                 cmd,
	output srfs_pkg::dp_stat_t                stat,
	output logic [srfs_pkg::STEP_W-1:0]       average_steps,
	output logic [srfs_pkg::TOTAL_W-1:0]      match_total,
	output logic                              max_found,
	output logic [srfs_pkg::STEP_W-1:0]       max_steps,
	output logic [srfs_pkg::DAY_W-1:0]        max_day,
	output logic [srfs_pkg::MON_W-1:0]        max_month,
	output logic [srfs_pkg::YEAR_W-1:0]       max_year
);

	import srfs_pkg::*;

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam int SUM_W = STEP_W + CNT_W;
	localparam int JP_W  = YY_W + 13;
	localparam int QP_W  = H_W + 12;
	localparam logic [STEP_W-1:0] STEP_MASK = (STEP_BITS >= STEP_W) ? {STEP_W{1'b1}} :
		STEP_W'((64'd1 << STEP_BITS) - 64'd1);

	// configuration
	logic [MODE_W-1:0] mode_q;
	logic [MON_W-1:0]  fmon_q;
	logic [WD_W-1:0]   fwd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ALL;
			fmon_q <= FMON_RESET;
			fwd_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MODE:    mode_q <= cfg_wdata[MODE_W-1:0];
				CFG_MONTH:   fmon_q <= cfg_wdata[MON_W-1:0];
				CFG_WEEKDAY: fwd_q  <= cfg_wdata[WD_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: shifted year and century
	logic            wrap;
	logic [YY_W-1:0] yy_in;
	logic [JP_W-1:0] jp;

	assign wrap  = rec_month < MON_W'(MONTH_WRAP);
	assign yy_in = YY_W'(rec_year) + YY_W'(YEAR_OFFSET) - YY_W'(wrap);
	assign jp    = JP_W'(yy_in) * JP_W'(RECIP100);

	logic              v_s1, v_s2, v_s3;
	logic [YY_W-1:0]   yy_s1;
	logic [J_W-1:0]    j_s1;
	logic [DAY_W-1:0]  day_s1, day_s2, day_s3;
	logic [MON_W-1:0]  mon_s1, mon_s2, mon_s3;
	logic [YEAR_W-1:0] year_s1, year_s2, year_s3;
	logic [STEP_W-1:0] steps_s1, steps_s2, steps_s3;
	logic [H_W-1:0]    h_s2, h_s3;
	logic [Q7_W-1:0]   q_s3;

	// stage 2: zeller sum
	logic [YY_W-1:0] kd;
	logic [K_W-1:0]  k;
	logic [H_W-1:0]  h;

	assign kd = yy_s1 - YY_W'(j_s1) * YY_W'(CENT);
	assign k  = kd[K_W-1:0];
	assign h  = H_W'(day_s1) + H_W'(month_term(mon_s1)) + H_W'(k) + H_W'(k >> 2)
		+ H_W'(j_s1 >> 2) + H_W'(j_s1) * H_W'(J_WEIGHT);

	// stage 3: quotient by seven
	logic [QP_W-1:0] qp;
	assign qp = QP_W'(h_s2) * QP_W'(RECIP7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		yy_s1    <= yy_in;
		j_s1     <= jp[RECIP100_SH +: J_W];
		day_s1   <= rec_day;
		mon_s1   <= rec_month;
		year_s1  <= rec_year;
		steps_s1 <= step_count & STEP_MASK;

		h_s2     <= h;
		day_s2   <= day_s1;
		mon_s2   <= mon_s1;
		year_s2  <= year_s1;
		steps_s2 <= steps_s1;

		h_s3     <= h_s2;
		q_s3     <= qp[RECIP7_SH +: Q7_W];
		day_s3   <= day_s2;
		mon_s3   <= mon_s2;
		year_s3  <= year_s2;
		steps_s3 <= steps_s2;
	end

	// filter and accumulate
	logic [H_W-1:0]  wdd;
	logic [WD_W-1:0] wd;
	logic            pass;
	logic            acc_en;

	assign wdd = h_s3 - H_W'(q_s3) * H_W'(WEEK);
	assign wd  = wdd[WD_W-1:0];

	always_comb begin
		case (mode_q)
			MODE_ALL:     pass = 1'b1;
			MODE_MONTH:   pass = mon_s3 == fmon_q;
			MODE_WEEKDAY: pass = wd == fwd_q;
			default:      pass = 1'b0;
		endcase
	end

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] best_steps_q;
	logic [DAY_W-1:0]  best_day_q;
	logic [MON_W-1:0]  best_month_q;
	logic [YEAR_W-1:0] best_year_q;

	assign acc_en = v_s3 && pass && (cnt_q < CNT_W'(MAX_RECORDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			cnt_q        <= '0;
			best_steps_q <= '0;
			best_day_q   <= '0;
			best_month_q <= '0;
			best_year_q  <= '0;
		end else if (cmd.start) begin
			sum_q        <= '0;
			cnt_q        <= '0;
			best_steps_q <= '0;
			best_day_q   <= '0;
			best_month_q <= '0;
			best_year_q  <= '0;
		end else if (acc_en) begin
			sum_q <= sum_q + SUM_W'(steps_s3);
			cnt_q <= cnt_q + 1'b1;
			if (steps_s3 > best_steps_q) begin
				best_steps_q <= steps_s3;
				best_day_q   <= day_s3;
				best_month_q <= mon_s3;
				best_year_q  <= year_s3;
			end
		end
	end

	// snapshot of a finished set while the divider runs
	logic [CNT_W-1:0]  snap_cnt_q;
	logic [STEP_W-1:0] snap_steps_q;
	logic [DAY_W-1:0]  snap_day_q;
	logic [MON_W-1:0]  snap_month_q;
	logic [YEAR_W-1:0] snap_year_q;
	logic [STEP_W-1:0] quo;
	logic              div_done;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			snap_cnt_q   <= cnt_q;
			snap_steps_q <= best_steps_q;
			snap_day_q   <= best_day_q;
			snap_month_q <= best_month_q;
			snap_year_q  <= best_year_q;
		end
	end

	srfs_div #(
		.DVD_W (SUM_W),
		.DVS_W (CNT_W),
		.Q_W   (STEP_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (quo)
	);

	// output register
	logic [STEP_W-1:0]  avg_q;
	logic [TOTAL_W-1:0] total_q;
	logic               found_q;
	logic [STEP_W-1:0]  mx_steps_q;
	logic [DAY_W-1:0]   mx_day_q;
	logic [MON_W-1:0]   mx_month_q;
	logic [YEAR_W-1:0]  mx_year_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			avg_q      <= (snap_cnt_q == '0) ? '0 : quo;
			total_q    <= TOTAL_W'(snap_cnt_q);
			found_q    <= snap_steps_q != '0;
			mx_steps_q <= snap_steps_q;
			mx_day_q   <= snap_day_q;
			mx_month_q <= snap_month_q;
			mx_year_q  <= snap_year_q;
		end
	end

	assign average_steps = avg_q;
	assign match_total   = total_q;
	assign max_found     = found_q;
	assign max_steps     = mx_steps_q;
	assign max_day       = mx_day_q;
	assign max_month     = mx_month_q;
	assign max_year      = mx_year_q;

	assign stat.pipe_busy = v_s1 || v_s2 || v_s3;
	assign stat.div_done  = div_done;

	a_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !(v_s1 || v_s2 || v_s3 || cmd.take))
		else $error("set closed with records still in the pipeline");

endmodule

@@ src/srfs_ctrl.sv @@
// controller: input gating, pipeline flush, divider sequencing, result handoff
// depends on srfs_pkg
module srfs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               is_last,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  srfs_pkg::dp_stat_t stat,
	output srfs_pkg::dp_cmd_t  cmd
);

	import srfs_pkg::*;

	typedef enum logic [3:0] {
		ST_ACC   = 4'b0001,
		ST_FLUSH = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.take     = 1'b0;
		cmd.start    = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_ACC: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && is_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!stat.pipe_busy) begin
					cmd.start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register loaded over a pending transaction");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && is_last) |=> (!in_ready && !cmd.start))
		else $error("input not closed after last record");

endmodule

@@ src/step_record_filtered_stats.sv @@
// Filtered statistics over a stream of daily step records.
// Input channel in_valid/in_ready carries one record per transaction:
// rec_day, rec_month, rec_year, step_count and is_last. Each record's
// weekday (0 Saturday .. 6 Friday) goes through a three-stage pipeline,
// then the record is tested against the filter (all, one month, one
// weekday or none) and summed, counted and compared for the strict maximum.
// Records are taken one per cycle while a set streams in. After the record
// marked last, in_ready stays low while the weekday pipeline drains, the set
// is closed, the radix-2 divider forms the average (one quotient bit per
// cycle) and the result is handed to the output register. Only the last
// record yields a result on out_valid/
// out_ready. The output register lets the next set stream while a result
// waits; if the receiver still holds the previous result when the next set
// finishes, the block waits for it before loading the new one.
// Configuration goes through cfg_we/cfg_idx/cfg_wdata, written while idle.
// Reset clears the accumulators, sets mode all, month 1, weekday 0, and
// leaves no result pending.
// Depends on srfs_pkg, srfs_ctrl, srfs_datapath and srfs_div.
module step_record_filtered_stats #(
	parameter int MAX_RECORDS = 65536,
	parameter int STEP_BITS   = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [srfs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [srfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [srfs_pkg::DAY_W-1:0]      rec_day,
	input  logic [srfs_pkg::MON_W-1:0]      rec_month,
	input  logic [srfs_pkg::YEAR_W-1:0]     rec_year,
	input  logic [srfs_pkg::STEP_W-1:0]     step_count,
	input  logic                            is_last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [srfs_pkg::STEP_W-1:0]     average_steps,
	output logic [srfs_pkg::TOTAL_W-1:0]    match_total,
	output logic                            max_found,
	output logic [srfs_pkg::STEP_W-1:0]     max_steps,
	output logic [srfs_pkg::DAY_W-1:0]      max_day,
	output logic [srfs_pkg::MON_W-1:0]      max_month,
	output logic [srfs_pkg::YEAR_W-1:0]     max_year
);

	import srfs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	srfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.is_last   (is_last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	srfs_datapath #(
		.MAX_RECORDS (MAX_RECORDS),
		.STEP_BITS   (STEP_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.rec_day       (rec_day),
		.rec_month     (rec_month),
		.rec_year      (rec_year),
		.step_count    (step_count),
		.cmd           (cmd),
		.stat          (stat),
		.average_steps (average_steps),
		.match_total   (match_total),
		.max_found     (max_found),
		.max_steps     (max_steps),
		.max_day       (max_day),
		.max_month     (max_month),
		.max_year      (max_year)
	);

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for step_record_filtered_stats: a directed vector table
// followed by random record sets under changing filters
// depends on srfs_pkg and step_record_filtered_stats
module tb_top;
	import srfs_pkg::*;

	localparam int MAX_RECORDS   = 65536;
	localparam int NUM_VEC       = 20;
	localparam int RANDOM_ITEMS  = 1300;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;

	// mode 3 has no name in the package and passes nothing
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic [STEP_W-1:0] steps;
		logic              last;
	} record_t;

	typedef struct packed {
		logic [STEP_W-1:0]  avg;
		logic [TOTAL_W-1:0] total;
		logic               found;
		logic [STEP_W-1:0]  peak;
		logic [DAY_W-1:0]   day;
		logic [MON_W-1:0]   month;
		logic [YEAR_W-1:0]  year;
	} summary_t;

	typedef struct packed {
		logic              load;
		logic [MODE_W-1:0] mode;
		logic [MON_W-1:0]  month;
		logic [WD_W-1:0]   weekday;
	} filter_t;

	typedef struct packed {
		logic     known;
		summary_t val;
	} fixed_t;

	typedef struct packed {
		filter_t filt;
		record_t rec;
		fixed_t  fixed;
	} vector_t;

	localparam filter_t KEEP_FILTER = '0;
	localparam fixed_t  PREDICTED   = '0;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [DAY_W-1:0]      rec_day;
	logic [MON_W-1:0]      rec_month;
	logic [YEAR_W-1:0]     rec_year;
	logic [STEP_W-1:0]     step_count;
	logic                  is_last;
	logic                  out_valid;
	logic                  out_ready;
	logic [STEP_W-1:0]     average_steps;
	logic [TOTAL_W-1:0]    match_total;
	logic                  max_found;
	logic [STEP_W-1:0]     max_steps;
	logic [DAY_W-1:0]      max_day;
	logic [MON_W-1:0]      max_month;
	logic [YEAR_W-1:0]     max_year;

	// filter copy and per-set accumulators of the predictor
	logic [MODE_W-1:0] flt_mode;
	logic [MON_W-1:0]  flt_month;
	logic [WD_W-1:0]   flt_weekday;
	longint unsigned   step_total;
	int                matched;
	record_t           leader;

	summary_t expected_summaries[$];
	int       mismatch_count;
	int       burst_left;
	bit       gaps_on;
	int       hold_tickets;
	vector_t  vectors [NUM_VEC];

	step_record_filtered_stats #(
		.MAX_RECORDS(MAX_RECORDS),
		.STEP_BITS(STEP_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rec_day(rec_day),
		.rec_month(rec_month),
		.rec_year(rec_year),
		.step_count(step_count),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average_steps(average_steps),
		.match_total(match_total),
		.max_found(max_found),
		.max_steps(max_steps),
		.max_day(max_day),
		.max_month(max_month),
		.max_year(max_year)
	);

	// 0 saturday .. 6 friday; year shifted by a full gregorian cycle
	function automatic int zeller_weekday(input int d, input int m, input int y);
		int yy, k, j, h;
		yy = y + 400;
		if (m < 3) begin
			m += 12;
			yy -= 1;
		end
		k = yy % 100;
		j = yy / 100;
		h = d + (m + 1) * 26 / 10 + k + k / 4 + j / 4 + 5 * j;
		return h % 7;
	endfunction

	task automatic tally_record(input record_t r, output bit closed, output summary_t s);
		bit pass;
		case (flt_mode)
			MODE_ALL:     pass = 1'b1;
			MODE_MONTH:   pass = (r.month == flt_month);
			MODE_WEEKDAY: pass = (zeller_weekday(int'(r.day), int'(r.month), int'(r.year))
			                      == int'(flt_weekday));
			default:      pass = 1'b0;
		endcase
		if (pass && matched < MAX_RECORDS) begin
			step_total += 64'(r.steps);
			matched++;
			if (r.steps > leader.steps) begin
				leader = r;
			end
		end
		closed = r.last;
		s = '0;
		if (closed) begin
			if (matched != 0) begin
				s.avg = STEP_W'(step_total / 64'(matched));
			end
			s.total = TOTAL_W'(matched);
			s.found = (leader.steps != '0);
			s.peak  = leader.steps;
			s.day   = leader.day;
			s.month = leader.month;
			s.year  = leader.year;
			step_total = 0;
			matched = 0;
			leader = '0;
		end
	endtask

	function automatic filter_t filt(input logic [MODE_W-1:0] mode, input int m, input int wd);
		filter_t f;
		f.load = 1'b1;
		f.mode = mode;
		f.month = MON_W'(m);
		f.weekday = WD_W'(wd);
		return f;
	endfunction

	function automatic record_t rec(input int d, input int m, input int y, input int s,
			input bit l);
		record_t r;
		r.day = DAY_W'(d);
		r.month = MON_W'(m);
		r.year = YEAR_W'(y);
		r.steps = STEP_W'(s);
		r.last = l;
		return r;
	endfunction

	function automatic fixed_t known(input int avg, input int total, input bit found,
			input int peak, input int d, input int m, input int y);
		fixed_t x;
		x.known = 1'b1;
		x.val.avg = STEP_W'(avg);
		x.val.total = TOTAL_W'(total);
		x.val.found = found;
		x.val.peak = STEP_W'(peak);
		x.val.day = DAY_W'(d);
		x.val.month = MON_W'(m);
		x.val.year = YEAR_W'(y);
		return x;
	endfunction

	function automatic string show(input summary_t s);
		return $sformatf("avg=%0d total=%0d found=%0d max=%0d on %0d/%0d/%0d",
			s.avg, s.total, s.found, s.peak, s.day, s.month, s.year);
	endfunction

	function automatic filter_t random_filter();
		filter_t f;
		f.load = 1'b1;
		case ($urandom_range(0, 9))
			0:       f.mode = MODE_NONE;
			1, 2, 3: f.mode = MODE_ALL;
			4, 5, 6: f.mode = MODE_MONTH;
			default: f.mode = MODE_WEEKDAY;
		endcase
		case ($urandom_range(0, 5))
			0:       f.month = MON_W'(1);
			1:       f.month = MON_W'(12);
			default: f.month = MON_W'($urandom_range(1, 12));
		endcase
		f.weekday = WD_W'($urandom_range(0, 6));
		return f;
	endfunction

	function automatic record_t random_record(input bit last);
		record_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// raw field codes, including day 0, month 0 and 13..15, years past 9999
			r.day = DAY_W'($urandom);
			r.month = MON_W'($urandom);
			r.year = YEAR_W'($urandom);
		end else begin
			r.day = DAY_W'($urandom_range(1, 31));
			if (flt_mode == MODE_MONTH && pick < 50) begin
				r.month = flt_month;
			end else begin
				r.month = MON_W'($urandom_range(1, 12));
			end
			case ($urandom_range(0, 9))
				0:       r.year = YEAR_W'(1);
				1:       r.year = YEAR_W'(9999);
				default: r.year = YEAR_W'($urandom_range(1, 9999));
			endcase
		end
		case ($urandom_range(0, 9))
			0:       r.steps = '0;
			1:       r.steps = '1;
			2, 3:    r.steps = STEP_W'($urandom_range(0, 3));
			default: r.steps = STEP_W'($urandom);
		endcase
		r.last = last;
		return r;
	endfunction

	task automatic send_record(input record_t r, input fixed_t fx);
		bit closed;
		summary_t s;
		int gap;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		in_valid <= 1'b1;
		rec_day <= r.day;
		rec_month <= r.month;
		rec_year <= r.year;
		step_count <= r.steps;
		is_last <= r.last;
		do @(posedge clk); while (!in_ready);
		tally_record(r, closed, s);
		if (closed) begin
			expected_summaries.push_back(fx.known ? fx.val : s);
		end
	endtask

	// wait until every summary is out and the pipeline is quiet, then load the filter
	task automatic apply_filter(input filter_t f);
		in_valid <= 1'b0;
		while (expected_summaries.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_MODE;
		cfg_wdata <= CFG_DATA_W'(f.mode);
		@(posedge clk);
		cfg_idx <= CFG_MONTH;
		cfg_wdata <= f.month;
		@(posedge clk);
		cfg_idx <= CFG_WEEKDAY;
		cfg_wdata <= CFG_DATA_W'(f.weekday);
		@(posedge clk);
		cfg_we <= 1'b0;
		flt_mode = f.mode;
		flt_month = f.month;
		flt_weekday = f.weekday;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : receiver
		int style, left, hold, served;
		bit [7:0] pattern;
		out_ready = 1'b0;
		style = 0;
		left = 0;
		hold = 0;
		served = 0;
		pattern = '0;
		forever begin
			@(posedge clk);
			if (hold_tickets != served) begin
				served++;
				hold = HOLD_CYCLES;
			end
			if (left == 0) begin
				style = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
				pattern = 8'($urandom);
			end
			left--;
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				case (style)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					2:       out_ready <= ($urandom_range(0, 7) == 0);
					default: out_ready <= pattern[left % 8];
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_summary
		summary_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {average_steps, match_total, max_found, max_steps, max_day, max_month,
				max_year};
			if (expected_summaries.size() == 0) begin
				if (mismatch_count < 10) begin
					$display("unexpected summary transaction: %s", show(got));
				end
				mismatch_count++;
			end else begin
				want = expected_summaries.pop_front();
				if (got.avg != want.avg || got.total != want.total ||
						got.found != want.found || got.peak != want.peak ||
						got.day != want.day || got.month != want.month ||
						got.year != want.year) begin
					if (mismatch_count < 10) begin
						$display("summary mismatch at %0t: expected %s, got %s", $realtime,
							show(want), show(got));
					end
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int items, phase, n_sets, set_len;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		rec_day = '0;
		rec_month = '0;
		rec_year = '0;
		step_count = '0;
		is_last = 1'b0;
		flt_mode = MODE_ALL;
		flt_month = FMON_RESET;
		flt_weekday = '0;
		step_total = 0;
		matched = 0;
		leader = '0;
		mismatch_count = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_tickets = 0;

		// reset filter: all records
		vectors[0]  = {KEEP_FILTER, rec(1, 1, 1, 0, 1), known(0, 1, 0, 0, 0, 0, 0)};
		vectors[1]  = {KEEP_FILTER, rec(31, 12, 9999, 'hFFFFFF, 1),
			known('hFFFFFF, 1, 1, 'hFFFFFF, 31, 12, 9999)};
		// tie for the maximum keeps the first
		vectors[2]  = {KEEP_FILTER, rec(5, 3, 2020, 100, 0), PREDICTED};
		vectors[3]  = {KEEP_FILTER, rec(6, 3, 2020, 100, 0), PREDICTED};
		vectors[4]  = {KEEP_FILTER, rec(7, 3, 2020, 50, 1), known(83, 3, 1, 100, 5, 3, 2020)};
		vectors[5]  = {filt(MODE_MONTH, 12, 0), rec(1, 12, 2000, 10, 0), PREDICTED};
		vectors[6]  = {KEEP_FILTER, rec(2, 11, 2000, 999, 0), PREDICTED};
		vectors[7]  = {KEEP_FILTER, rec(3, 12, 2000, 20, 1), known(15, 2, 1, 20, 3, 12, 2000)};
		// only a zero-step record matches
		vectors[8]  = {filt(MODE_MONTH, 1, 6), rec(9, 2, 1999, 500, 0), PREDICTED};
		vectors[9]  = {KEEP_FILTER, rec(10, 1, 1999, 0, 1), known(0, 1, 0, 0, 0, 0, 0)};
		// weekday filter over january, february, zero and odd codes
		vectors[10] = {filt(MODE_WEEKDAY, 1, 0), rec(1, 1, 2000, 1000, 1), PREDICTED};
		vectors[11] = {KEEP_FILTER, rec(29, 2, 2000, 7, 1), PREDICTED};
		vectors[12] = {KEEP_FILTER, rec(0, 0, 0, 8, 1), PREDICTED};
		vectors[13] = {KEEP_FILTER, rec(31, 15, 16383, 9, 1), PREDICTED};
		vectors[14] = {KEEP_FILTER, rec(15, 13, 0, 10, 1), PREDICTED};
		vectors[15] = {KEEP_FILTER, rec(1, 3, 1, 11, 1), PREDICTED};
		vectors[16] = {filt(MODE_WEEKDAY, 12, 6), rec(7, 1, 2000, 12, 1), PREDICTED};
		vectors[17] = {KEEP_FILTER, rec(14, 14, 5000, 13, 1), PREDICTED};
		// unused mode matches nothing
		vectors[18] = {filt(MODE_NONE, 12, 6), rec(1, 1, 2000, 77, 0), PREDICTED};
		vectors[19] = {KEEP_FILTER, rec(2, 1, 2000, 88, 1), known(0, 0, 0, 0, 0, 0, 0)};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[i]) begin
			if (vectors[i].filt.load) begin
				apply_filter(vectors[i].filt);
			end
			send_record(vectors[i].rec, vectors[i].fixed);
		end

		items = 0;
		phase = 0;
		while (items < RANDOM_ITEMS) begin
			apply_filter(random_filter());
			gaps_on = !(phase % 4 == 3 || phase == 2);
			// long receiver hold-off while short sets keep coming
			if (phase == 2) begin
				hold_tickets++;
			end
			n_sets = (phase == 2) ? 20 : $urandom_range(3, 12);
			repeat (n_sets) begin
				if (phase == 2) begin
					set_len = $urandom_range(1, 3);
				end else begin
					case ($urandom_range(0, 19))
						0, 1, 2, 3, 4, 5, 6, 7:         set_len = $urandom_range(1, 3);
						8, 9, 10, 11, 12, 13, 14, 15:   set_len = $urandom_range(4, 12);
						16, 17, 18:                     set_len = $urandom_range(13, 40);
						default:                        set_len = 1;
					endcase
				end
				for (int i = 0; i < set_len; i++) begin
					send_record(random_record(i == set_len - 1), PREDICTED);
				end
				items += set_len;
			end
			phase++;
		end

		in_valid <= 1'b0;
		while (expected_summaries.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
